### rtl/pcea_pkg.sv
// Shared constants, codes and types for the charge and energy accumulator.
`timescale 1ns / 1ps

package pcea_pkg;

  // Serial multiplier: 32-bit multiplicand, one multiplier bit per step
  localparam int MCAND_W = 32;
  localparam int MPLR_W  = 20;
  localparam int PROD_W  = MCAND_W + MPLR_W;

  // Serial divider: restoring, one quotient bit per step
  localparam int DIVIDEND_W = 46;
  localparam int QUO_W      = 24;
  localparam int DVSR_W     = DIVIDEND_W - QUO_W;

  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MPLR_W);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(QUO_W);
  // Extra count after the last divide step, where the quotient is read
  localparam logic [CNT_W-1:0] DIV_DONE  = CNT_W'(QUO_W + 1);

  localparam logic [DVSR_W-1:0]     MS_PER_HOUR = 22'd3600000;
  localparam logic [DVSR_W-1:0]     MW_PER_UNIT = 22'd1000;
  localparam logic [34:0]           ROUND_HALF  = 35'd500;
  localparam logic [34:0]           SAT_LIMIT   = 35'd1000000000;
  localparam logic [19:0]           POWER_MAX   = 20'd999999;
  localparam logic [DIVIDEND_W-1:0] TOTAL_CAP   = 46'd35999996400000;
  localparam logic [5:0]            SIXTY_LAST  = 6'd59;
  localparam logic [6:0]            HOURS_MAX   = 7'd99;

  localparam logic [1:0] ACT_MEASURE = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
  } pcea_ctl_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL1 = 7'b0000010,
    ST_DIVP = 7'b0000100,
    ST_MUL2 = 7'b0001000,
    ST_ACC  = 7'b0010000,
    ST_DIVT = 7'b0100000,
    ST_OUT  = 7'b1000000
  } pcea_state_t;

endpackage

### rtl/pcea_sermul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per step.
`timescale 1ns / 1ps

module pcea_sermul (
  input  logic                          clk,
  input  pcea_pkg::pcea_ctl_t           ctl,
  input  logic [pcea_pkg::MCAND_W-1:0]  mcand_in,
  input  logic [pcea_pkg::MPLR_W-1:0]   mplr_in,
  output logic [pcea_pkg::PROD_W-1:0]   prod
);

  logic [pcea_pkg::MCAND_W-1:0] mcand;
  logic [pcea_pkg::MCAND_W:0]   hi_sum;
  logic [pcea_pkg::PROD_W-1:0]  prod_next;

  always_comb begin
    hi_sum = {1'b0, prod[pcea_pkg::PROD_W-1:pcea_pkg::MPLR_W]}
           + (prod[0] ? {1'b0, mcand} : '0);
    prod_next = {hi_sum, prod[pcea_pkg::MPLR_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand <= mcand_in;
      prod  <= {{pcea_pkg::MCAND_W{1'b0}}, mplr_in};
    end else if (ctl.step) begin
      prod <= prod_next;
    end
  end

endmodule

### rtl/pcea_serdiv.sv
// Restoring divider, one quotient bit per step.
`timescale 1ns / 1ps

module pcea_serdiv (
  input  logic                             clk,
  input  pcea_pkg::pcea_ctl_t              ctl,
  input  logic [pcea_pkg::DIVIDEND_W-1:0]  dividend_in,
  input  logic [pcea_pkg::DVSR_W-1:0]      divisor_in,
  output logic [pcea_pkg::QUO_W-1:0]       quo
);

  logic [pcea_pkg::DVSR_W-1:0] rem;
  logic [pcea_pkg::DVSR_W-1:0] dvsr;
  logic [pcea_pkg::DVSR_W:0]   trial;
  logic [pcea_pkg::DVSR_W:0]   diff;
  logic                        ge;

  // The dividend's upper part must stay below the divisor, so the quotient fits
  always_comb begin
    trial = {rem, quo[pcea_pkg::QUO_W-1]};
    diff  = trial - {1'b0, dvsr};
    ge    = (trial >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem  <= dividend_in[pcea_pkg::DIVIDEND_W-1:pcea_pkg::QUO_W];
      quo  <= dividend_in[pcea_pkg::QUO_W-1:0];
      dvsr <= divisor_in;
    end else if (ctl.step) begin
      rem <= ge ? diff[pcea_pkg::DVSR_W-1:0] : trial[pcea_pkg::DVSR_W-1:0];
      quo <= {quo[pcea_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

### rtl/power_charge_energy_accumulator.sv
// Top level of the charge and energy accumulator with runtime clock.
// Sequence: a measurement word passes through the phases MUL1, DIVP, MUL2, ACC,
//   DIVT and OUT in turn; tick, clear and unused action words go straight to OUT.
// Throughput: in_stall holds off a new word until the last one reaches the output
//   register, set by the serial multipliers and the restoring dividers in sequence.
// Reset: synchronous; zeroes stamps, totals, power and runtime, empties the output.
`timescale 1ns / 1ps

module power_charge_energy_accumulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [16:0] voltage_mv,
  input  logic [16:0] current_ma,
  input  logic [31:0] stamp_ms,
  input  logic        reply_in_time,
  input  logic        run_enable,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] power_mw,
  output logic        power_changed,
  output logic [23:0] charge_mah,
  output logic [23:0] energy_mwh,
  output logic [6:0]  run_hours,
  output logic [5:0]  run_minutes,
  output logic [5:0]  run_seconds
);

  pcea_pkg::pcea_state_t state;
  logic [pcea_pkg::CNT_W-1:0] cnt;

  // Architectural state
  logic [31:0] newest_stamp;
  logic [31:0] older_stamp;
  logic [pcea_pkg::DIVIDEND_W-1:0] charge_total;
  logic [pcea_pkg::DIVIDEND_W-1:0] energy_total;
  logic [19:0] previous_power;
  logic [5:0]  elapsed_seconds;
  logic [5:0]  elapsed_minutes;
  logic [6:0]  elapsed_hours;
  // Totals converted to hour units, kept so ticks need no division
  logic [23:0] charge_q;
  logic [23:0] energy_q;

  // Working registers of one measurement
  logic [16:0] volt_r;
  logic [16:0] curr_r;
  logic [31:0] dt;
  logic        sat;
  logic        chg;

  pcea_pkg::pcea_ctl_t mula_ctl, mulb_ctl, divp_ctl, divt_ctl;
  logic [pcea_pkg::MCAND_W-1:0]    mula_mcand;
  logic [pcea_pkg::MPLR_W-1:0]     mula_mplr;
  logic [pcea_pkg::PROD_W-1:0]     mula_prod;
  logic [pcea_pkg::PROD_W-1:0]     mulb_prod;
  logic [pcea_pkg::QUO_W-1:0]      divp_quo;
  logic [pcea_pkg::QUO_W-1:0]      divc_quo;
  logic [pcea_pkg::QUO_W-1:0]      dive_quo;
  logic [34:0]                     rounded;
  logic [pcea_pkg::DIVIDEND_W-1:0] divp_dividend;
  logic [19:0]                     power_val;
  logic [pcea_pkg::PROD_W:0]       charge_sum;
  logic [pcea_pkg::PROD_W:0]       energy_sum;
  logic                            out_free;

  assign in_stall = (state != pcea_pkg::ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Sequencer controls: the first cycle of a phase loads a unit, the rest step it;
  // a divide phase holds its last cycle so the finished quotient can be read
  always_comb begin
    mula_ctl.load = ((state == pcea_pkg::ST_MUL1) || (state == pcea_pkg::ST_MUL2))
                    && (cnt == '0);
    mula_ctl.step = ((state == pcea_pkg::ST_MUL1) || (state == pcea_pkg::ST_MUL2))
                    && (cnt != '0);
    mulb_ctl.load = (state == pcea_pkg::ST_MUL1) && (cnt == '0);
    mulb_ctl.step = (state == pcea_pkg::ST_MUL1) && (cnt != '0);
    divp_ctl.load = (state == pcea_pkg::ST_DIVP) && (cnt == '0);
    divp_ctl.step = (state == pcea_pkg::ST_DIVP) && (cnt != '0)
                    && (cnt != pcea_pkg::DIV_DONE);
    divt_ctl.load = (state == pcea_pkg::ST_DIVT) && (cnt == '0);
    divt_ctl.step = (state == pcea_pkg::ST_DIVT) && (cnt != '0)
                    && (cnt != pcea_pkg::DIV_DONE);
  end

  // Unit A forms volt * curr first, then power * interval
  always_comb begin
    if (state == pcea_pkg::ST_MUL2) begin
      mula_mcand = dt;
      mula_mplr  = previous_power;
    end else begin
      mula_mcand = {15'b0, volt_r};
      mula_mplr  = {3'b0, curr_r};
    end
  end

  // Round half up, then divide by 1000; saturate where the rounded sum reaches 1e9
  always_comb begin
    rounded       = {1'b0, mula_prod[33:0]} + pcea_pkg::ROUND_HALF;
    divp_dividend = {11'b0, rounded};
    power_val     = sat ? pcea_pkg::POWER_MAX : divp_quo[19:0];
    charge_sum    = {7'b0, charge_total} + {1'b0, mulb_prod};
    energy_sum    = {7'b0, energy_total} + {1'b0, mula_prod};
  end

  pcea_sermul u_mula (
    .clk      (clk),
    .ctl      (mula_ctl),
    .mcand_in (mula_mcand),
    .mplr_in  (mula_mplr),
    .prod     (mula_prod)
  );

  pcea_sermul u_mulb (
    .clk      (clk),
    .ctl      (mulb_ctl),
    .mcand_in (dt),
    .mplr_in  ({3'b0, curr_r}),
    .prod     (mulb_prod)
  );

  pcea_serdiv u_divp (
    .clk         (clk),
    .ctl         (divp_ctl),
    .dividend_in (divp_dividend),
    .divisor_in  (pcea_pkg::MW_PER_UNIT),
    .quo         (divp_quo)
  );

  pcea_serdiv u_divc (
    .clk         (clk),
    .ctl         (divt_ctl),
    .dividend_in (charge_total),
    .divisor_in  (pcea_pkg::MS_PER_HOUR),
    .quo         (divc_quo)
  );

  pcea_serdiv u_dive (
    .clk         (clk),
    .ctl         (divt_ctl),
    .dividend_in (energy_total),
    .divisor_in  (pcea_pkg::MS_PER_HOUR),
    .quo         (dive_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= pcea_pkg::ST_IDLE;
      cnt             <= '0;
      out_valid       <= 1'b0;
      newest_stamp    <= '0;
      older_stamp     <= '0;
      charge_total    <= '0;
      energy_total    <= '0;
      previous_power  <= '0;
      elapsed_seconds <= '0;
      elapsed_minutes <= '0;
      elapsed_hours   <= '0;
      charge_q        <= '0;
      energy_q        <= '0;
    end else begin
      // Drop the output word once taken, unless ST_OUT below loads the next one
      if (out_valid && !out_stall && (state != pcea_pkg::ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        pcea_pkg::ST_IDLE: begin
          if (in_valid) begin
            chg <= 1'b0;
            cnt <= '0;
            case (action)
              pcea_pkg::ACT_MEASURE: begin
                volt_r <= voltage_mv;
                curr_r <= current_ma;
                // Record the stamp when the meters replied in time, else reuse the interval
                if (reply_in_time) begin
                  older_stamp  <= newest_stamp;
                  newest_stamp <= stamp_ms;
                  dt           <= stamp_ms - newest_stamp;
                end else begin
                  dt <= newest_stamp - older_stamp;
                end
                state <= pcea_pkg::ST_MUL1;
              end
              pcea_pkg::ACT_TICK: begin
                // Seconds and minutes wrap; hours hold at their limit
                if (run_enable) begin
                  if (elapsed_seconds < pcea_pkg::SIXTY_LAST) begin
                    elapsed_seconds <= elapsed_seconds + 6'd1;
                  end else begin
                    elapsed_seconds <= '0;
                    if (elapsed_minutes < pcea_pkg::SIXTY_LAST) begin
                      elapsed_minutes <= elapsed_minutes + 6'd1;
                    end else begin
                      elapsed_minutes <= '0;
                      if (elapsed_hours < pcea_pkg::HOURS_MAX) begin
                        elapsed_hours <= elapsed_hours + 7'd1;
                      end
                    end
                  end
                end
                state <= pcea_pkg::ST_OUT;
              end
              pcea_pkg::ACT_CLEAR: begin
                // Stamps and the last power survive a clear
                charge_total    <= '0;
                energy_total    <= '0;
                charge_q        <= '0;
                energy_q        <= '0;
                elapsed_seconds <= '0;
                elapsed_minutes <= '0;
                elapsed_hours   <= '0;
                state           <= pcea_pkg::ST_OUT;
              end
              default: begin
                state <= pcea_pkg::ST_OUT;
              end
            endcase
          end
        end
        pcea_pkg::ST_MUL1: begin
          if (cnt == pcea_pkg::MUL_STEPS) begin
            cnt   <= '0;
            state <= pcea_pkg::ST_DIVP;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        pcea_pkg::ST_DIVP: begin
          if (cnt == '0) begin
            sat <= (rounded >= pcea_pkg::SAT_LIMIT);
          end
          if (cnt == pcea_pkg::DIV_DONE) begin
            chg            <= (power_val != previous_power);
            previous_power <= power_val;
            cnt            <= '0;
            state          <= pcea_pkg::ST_MUL2;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        pcea_pkg::ST_MUL2: begin
          if (cnt == pcea_pkg::MUL_STEPS) begin
            cnt   <= '0;
            state <= pcea_pkg::ST_ACC;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        pcea_pkg::ST_ACC: begin
          // Add both products and clamp each total at its cap
          charge_total <= (charge_sum > {7'b0, pcea_pkg::TOTAL_CAP}) ?
                          pcea_pkg::TOTAL_CAP : charge_sum[pcea_pkg::DIVIDEND_W-1:0];
          energy_total <= (energy_sum > {7'b0, pcea_pkg::TOTAL_CAP}) ?
                          pcea_pkg::TOTAL_CAP : energy_sum[pcea_pkg::DIVIDEND_W-1:0];
          cnt   <= '0;
          state <= pcea_pkg::ST_DIVT;
        end
        pcea_pkg::ST_DIVT: begin
          if (cnt == pcea_pkg::DIV_DONE) begin
            charge_q <= divc_quo;
            energy_q <= dive_quo;
            cnt      <= '0;
            state    <= pcea_pkg::ST_OUT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        pcea_pkg::ST_OUT: begin
          // Hold the finished word until the output register is free
          if (out_free) begin
            power_mw      <= previous_power;
            power_changed <= chg;
            charge_mah    <= charge_q;
            energy_mwh    <= energy_q;
            run_hours     <= elapsed_hours;
            run_minutes   <= elapsed_minutes;
            run_seconds   <= elapsed_seconds;
            out_valid     <= 1'b1;
            state         <= pcea_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= pcea_pkg::ST_IDLE;
        end
      endcase
    end
  end

  a_charge_capped: assert property (@(posedge clk) disable iff (rst)
    charge_total <= pcea_pkg::TOTAL_CAP)
    else $error("charge total above cap");

  a_energy_capped: assert property (@(posedge clk) disable iff (rst)
    energy_total <= pcea_pkg::TOTAL_CAP)
    else $error("energy total above cap");

  a_runtime_range: assert property (@(posedge clk) disable iff (rst)
    (elapsed_seconds <= pcea_pkg::SIXTY_LAST) && (elapsed_minutes <= pcea_pkg::SIXTY_LAST)
    && (elapsed_hours <= pcea_pkg::HOURS_MAX))
    else $error("runtime out of range");

  a_power_range: assert property (@(posedge clk) disable iff (rst)
    previous_power <= pcea_pkg::POWER_MAX)
    else $error("power above saturation limit");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == pcea_pkg::ST_OUT) && out_free |=> out_valid && !in_stall)
    else $error("finished word not presented");

endmodule
